// ===== rtl/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants of the session table
// slot count, field widths, command kinds, result codes, register map
// ----------------------------------------------------------------------------
package sta_pkg;

	localparam int SLOTS      = 8;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int DEV_W  = 48;
	localparam int TIME_W = 32;
	localparam int LIFE_W = 16;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 8;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;

	localparam logic [15:0] LIFETIME_RESET = 16'd180;

	// register index is paddr[3], registers sit 8 bytes apart
	localparam logic REG_MASTER   = 1'b0;
	localparam logic REG_LIFETIME = 1'b1;

	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_LOGIN = 1'b1;

	typedef enum logic [1:0] {
		CMD_MASTER     = 2'd0,
		CMD_QUERY_SCAN = 2'd1,
		CMD_LOGIN      = 2'd2,
		CMD_BAD_CRED   = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		RC_UNKNOWN  = 3'd0,
		RC_MASTER   = 3'd1,
		RC_IN_TABLE = 3'd2,
		RC_STORED   = 3'd3,
		RC_BAD_CRED = 3'd4,
		RC_FULL     = 3'd5
	} rc_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [DEV_W-1:0]    device;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   expiry;
	} cmd_t;

endpackage

// ===== rtl/sta_front.sv =====
// ----------------------------------------------------------------------------
// sta_front: request classifier
// unpacks the input word, sorts it into a command kind, precomputes expiry
// ----------------------------------------------------------------------------
module sta_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sta_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic [sta_pkg::DEV_W-1:0]     master_device,
	input  logic [sta_pkg::LIFE_W-1:0]    lifetime_seconds,
	output logic                          push_valid,
	input  logic                          push_ready,
	output sta_pkg::cmd_t                 push_cmd
);
	import sta_pkg::*;

	logic [DEV_W-1:0]  device_id;
	logic              credentials_ok;
	logic [TIME_W-1:0] now_seconds;

	assign device_id      = s_tdata[DEV_W-1:0];
	assign credentials_ok = s_tdata[DEV_W];
	assign now_seconds    = s_tdata[DEV_W+TIME_W:DEV_W+1];

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_cmd.device = device_id;
		push_cmd.now    = now_seconds;
		// expiry wraps modulo 2^32
		push_cmd.expiry = now_seconds + TIME_W'(lifetime_seconds);
		if (s_tuser == ACT_QUERY) begin
			push_cmd.kind = (device_id == master_device) ? CMD_MASTER : CMD_QUERY_SCAN;
		end else begin
			push_cmd.kind = credentials_ok ? CMD_LOGIN : CMD_BAD_CRED;
		end
	end

endmodule

// ===== rtl/sta_queue.sv =====
// ----------------------------------------------------------------------------
// sta_queue: two-entry command queue
// decouples the classifier from the table scanner
// ----------------------------------------------------------------------------
module sta_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  sta_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output sta_pkg::cmd_t pop_cmd
);
	import sta_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			priority if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/sta_back.sv =====
// ----------------------------------------------------------------------------
// sta_back: table scanner and result stage
// walks the slots one per cycle, ages them, looks up or stores a device
// ----------------------------------------------------------------------------
module sta_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  sta_pkg::cmd_t                  pop_cmd,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sta_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sta_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic                  found_q;
	logic                  free_found_q;
	logic [SLOT_IDX_W-1:0] free_idx_q;

	logic [DEV_W-1:0]  slot_device_q [SLOTS];
	logic [TIME_W-1:0] slot_expiry_q [SLOTS];

	logic              out_valid_q;
	logic              granted_q;
	rc_t               code_q;

	logic [DEV_W-1:0]  rd_dev;
	logic [TIME_W-1:0] rd_exp;
	logic              expired;
	logic              live;
	logic              last_slot;
	logic              out_free;
	logic              finish;
	logic              store;
	logic              res_granted;
	rc_t               res_code;

	assign rd_dev    = slot_device_q[idx_q];
	assign rd_exp    = slot_expiry_q[idx_q];
	assign expired   = (rd_dev != '0) && (cmd_q.now > rd_exp);
	assign live      = (rd_dev != '0) && !expired;
	assign last_slot = (idx_q == SLOT_IDX_W'(SLOTS - 1));
	assign out_free  = !out_valid_q || m_tready;
	assign finish    = (state_q == ST_DONE) && out_free;
	assign store     = finish && (cmd_q.kind == CMD_LOGIN) && free_found_q;
	assign pop_ready = (state_q == ST_IDLE);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, code_q, granted_q};

	always_comb begin
		unique case (cmd_q.kind)
			CMD_MASTER: begin
				res_granted = 1'b1;
				res_code    = RC_MASTER;
			end
			CMD_QUERY_SCAN: begin
				res_granted = found_q;
				res_code    = found_q ? RC_IN_TABLE : RC_UNKNOWN;
			end
			CMD_LOGIN: begin
				res_granted = free_found_q;
				res_code    = free_found_q ? RC_STORED : RC_FULL;
			end
			default: begin
				res_granted = 1'b0;
				res_code    = RC_BAD_CRED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// a new word replaces the one taken in the same cycle
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (live && (rd_dev == cmd_q.device)) found_q <= 1'b1;
					if (!live && !free_found_q) free_found_q <= 1'b1;
					if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + SLOT_IDX_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) cmd_q <= pop_cmd;
		if (state_q == ST_SCAN && !live && !free_found_q) free_idx_q <= idx_q;
		if (finish) begin
			granted_q <= res_granted;
			code_q    <= res_code;
		end
	end

	// device column: cleared at reset, aged during the scan, written on store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_device_q[i] <= '0;
		end else begin
			priority if (state_q == ST_SCAN && expired) begin
				slot_device_q[idx_q] <= '0;
			end else if (store) begin
				slot_device_q[free_idx_q] <= cmd_q.device;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) slot_expiry_q[free_idx_q] <= cmd_q.expiry;
	end

endmodule

// ===== rtl/session_table_with_aging_core.sv =====
// ----------------------------------------------------------------------------
// session_table_with_aging_core: device session table with expiry
// keeps logged-in device ids, grants queries, stores logins, ages entries
// ----------------------------------------------------------------------------
// usage
//   request words enter on s_*: tuser is the action (0 query, 1 login),
//   tdata carries device id, credentials flag and the current time
//   one result word leaves on m_* for every request: granted flag and code
//   master id and login lifetime are set through the apb port; the user must
//   write them only while no request is in flight (not enforced by the block)
// scan
//   the back end walks all SLOTS table entries, one per cycle, through a
//   single read port of the table, and takes the next request from the
//   queue only once the result of the last has gone to its output register
// reset
//   arst_n empties the queue, drops any pending result and frees all slots;
//   master id returns to 0 and lifetime to 180 seconds
// stalls
//   a held result does not block the front at once: up to two requests queue up,
//   and the scanner takes and scans one more before it waits for m_tready
// ----------------------------------------------------------------------------
module session_table_with_aging_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [47:0] device_id, [48] credentials_ok, [80:49] now_seconds, [87:81] zero
	input  logic [sta_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] action
	input  logic                           s_tuser,
	// result channel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] granted, [3:1] result_code, [7:4] zero
	output logic [sta_pkg::OUT_DATA_W-1:0] m_tdata,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sta_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sta_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sta_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import sta_pkg::*;

	// configuration registers
	logic [DEV_W-1:0]  master_device_q;
	logic [LIFE_W-1:0] lifetime_seconds_q;
	logic              cfg_wr;
	logic              reg_sel;

	// front to queue, queue to back
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_device_q    <= '0;
			lifetime_seconds_q <= LIFETIME_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MASTER:   master_device_q    <= pwdata[DEV_W-1:0];
				REG_LIFETIME: lifetime_seconds_q <= pwdata[LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MASTER:   prdata = APB_DATA_W'(master_device_q);
			REG_LIFETIME: prdata = APB_DATA_W'(lifetime_seconds_q);
			default:      prdata = '0;
		endcase
	end

	// front: classify the request and precompute the expiry time
	sta_front u_front (
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.master_device    (master_device_q),
		.lifetime_seconds (lifetime_seconds_q),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_cmd         (push_cmd)
	);

	// two-entry queue between classifier and scanner
	sta_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: age and search the slots, store logins, hold the result word
	sta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
